FILE: sv/bcu_pkg.sv
// bcu_pkg: shared types, constants and control store for the binomial coefficient unit.
// Depends on nothing; imported by bcu_if.sv and binomial_coefficient_unit_top.sv.
package bcu_pkg;

   localparam int SET_W      = 6;    // n and k
   localparam int VALUE_W    = 63;   // result value
   localparam int PROD_W     = 64;   // running product, wide enough for C(n,i)*(n-i)
   localparam int DIGIT_BITS = 4;    // quotient bits resolved per divide cycle
   localparam int DIGITS     = PROD_W / DIGIT_BITS;
   localparam int DIG_W      = $clog2(DIGITS);
   localparam int STEP_W     = 3;

   typedef logic [STEP_W-1:0] step_type;

   // control store addresses
   localparam step_type STEP_IDLE = 3'd0;
   localparam step_type STEP_INIT = 3'd1;
   localparam step_type STEP_ADD  = 3'd2;
   localparam step_type STEP_MUL  = 3'd3;
   localparam step_type STEP_DIV  = 3'd4;
   localparam step_type STEP_INC  = 3'd5;
   localparam step_type STEP_EMIT = 3'd6;
   localparam step_type STEP_RET  = 3'd7;

   localparam logic CMD_SINGLE = 1'b0;
   localparam logic CMD_SUM    = 1'b1;

   typedef enum logic [2:0] {
      OP_WAIT,   // take a request beat
      OP_INIT,   // set up product, sum, index and limit
      OP_ADD,    // accumulate current term (sum command)
      OP_MUL,    // product *= n - i
      OP_DIV,    // one digit of product /= i + 1
      OP_INC,    // i += 1
      OP_EMIT,   // load the response register
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,       // fall through
      COND_ALWAYS,
      COND_NO_REQ,     // no request beat this cycle
      COND_LAST,       // index has reached the limit
      COND_DIG_LEFT,   // divide digits still to do
      COND_RSP_BUSY    // response register still held
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      logic             command;
      logic [SET_W-1:0] set_size;
      logic [SET_W-1:0] subset_size;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               out_of_range;
   } rsp_payload_type;

   // program: jump to target when the condition holds, else step on
   function automatic ucode_type ucode_rom(input step_type addr);
      ucode_type w;
      case (addr)
         STEP_IDLE: w = '{op: OP_WAIT, cond: COND_NO_REQ,   target: STEP_IDLE};
         STEP_INIT: w = '{op: OP_INIT, cond: COND_NEXT,     target: STEP_IDLE};
         STEP_ADD:  w = '{op: OP_ADD,  cond: COND_LAST,     target: STEP_EMIT};
         STEP_MUL:  w = '{op: OP_MUL,  cond: COND_NEXT,     target: STEP_IDLE};
         STEP_DIV:  w = '{op: OP_DIV,  cond: COND_DIG_LEFT, target: STEP_DIV};
         STEP_INC:  w = '{op: OP_INC,  cond: COND_ALWAYS,   target: STEP_ADD};
         STEP_EMIT: w = '{op: OP_EMIT, cond: COND_RSP_BUSY, target: STEP_EMIT};
         STEP_RET:  w = '{op: OP_NOP,  cond: COND_ALWAYS,   target: STEP_IDLE};
         default:   w = '{op: OP_NOP,  cond: COND_ALWAYS,   target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

FILE: sv/bcu_if.sv
// bcu_if: valid/ready channel interfaces for request and response beats.
// Depends on bcu_pkg for the payload types.
interface bcu_req_if import bcu_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bcu_rsp_if import bcu_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/binomial_coefficient_unit_top.sv
// Each request is worked in L rounds of multiply and divide, L = min(k, n-k) for a single
// coefficient, min(k, n) for a sum, 0 when k > n (single) or n is out of range.
// The unit works one item at a time; the next request beat is taken
// once the item has been handed to the response register, which may still wait on the sink.
// All rounds use the one 64-bit divider, 4 quotient bits per cycle.
// Reset (synchronous, active high) returns the sequencer to idle and drops response valid.
module binomial_coefficient_unit_top
   import bcu_pkg::*;
#(
   parameter int MAX_SET_SIZE = 62
) (
   input  logic       clock,
   input  logic       reset,
   bcu_req_if.sink    req_chan,
   bcu_rsp_if.source  rsp_chan
);

   // sequencer
   step_type  pc_ff, pc_in;
   ucode_type uc;
   logic      jump;

   // operand and datapath registers
   logic               cmd_ff, cmd_in;
   logic [SET_W-1:0]   n_ff, n_in;
   logic [SET_W-1:0]   k_ff, k_in;
   logic [SET_W-1:0]   i_ff, i_in;
   logic [SET_W-1:0]   lim_ff, lim_in;
   logic               oor_ff, oor_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [SET_W-1:0]   rem_ff, rem_in;
   logic [DIG_W-1:0]   dig_ff, dig_in;

   // response register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic               req_fire;
   logic               rsp_busy;
   logic               emit_load;
   logic [SET_W-1:0]   n_minus_k;
   logic [SET_W-1:0]   n_minus_i;
   logic [SET_W:0]     divisor;
   logic [PROD_W-1:0]  mul_res;
   logic [PROD_W-1:0]  div_quo;
   logic [SET_W-1:0]   div_rem;
   logic [VALUE_W-1:0] result;

   localparam logic [DIG_W-1:0] DigitLast = DIG_W'(DIGITS - 1);

   assign uc       = ucode_rom(pc_ff);
   assign req_chan.ready = (uc.op == OP_WAIT);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_busy = rsp_valid_ff && !rsp_chan.ready;
   assign emit_load = (uc.op == OP_EMIT) && !rsp_busy;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   // ---- next step ----
   always_comb begin
      case (uc.cond)
         COND_NEXT:     jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_REQ:   jump = !req_fire;
         COND_LAST:     jump = (i_ff == lim_ff);
         COND_DIG_LEFT: jump = (dig_ff != DigitLast);
         COND_RSP_BUSY: jump = rsp_busy;
         default:       jump = 1'b1;
      endcase
      pc_in = jump ? uc.target : pc_ff + step_type'(1);
   end

   // ---- arithmetic ----
   assign n_minus_k = n_ff - k_ff;
   assign n_minus_i = n_ff - i_ff;
   assign divisor   = {1'b0, i_ff} + (SET_W+1)'(1);
   // product times (n - i) stays below 2^64 for n up to 62
   assign mul_res   = prod_ff * {{(PROD_W-SET_W){1'b0}}, n_minus_i};

   // restoring division, DIGIT_BITS quotient bits per cycle, quotient shifts in at the bottom
   always_comb begin
      logic [SET_W:0]    r;
      logic [PROD_W-1:0] q;
      r = {1'b0, rem_ff};
      q = prod_ff;
      for (int j = 0; j < DIGIT_BITS; j++) begin
         r = {r[SET_W-1:0], q[PROD_W-1]};
         q = {q[PROD_W-2:0], 1'b0};
         if (r >= divisor) begin
            r    = r - divisor;
            q[0] = 1'b1;
         end
      end
      div_quo = q;
      div_rem = r[SET_W-1:0];
   end

   always_comb begin
      if (oor_ff)
         result = '0;
      else if (cmd_ff == CMD_SUM)
         result = acc_ff;
      else
         result = prod_ff[VALUE_W-1:0];
   end

   // ---- datapath control ----
   always_comb begin
      cmd_in  = cmd_ff;
      n_in    = n_ff;
      k_in    = k_ff;
      i_in    = i_ff;
      lim_in  = lim_ff;
      oor_in  = oor_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      dig_in  = dig_ff;
      rsp_payload_in = rsp_payload_ff;
      case (uc.op)
         OP_WAIT: begin
            cmd_in = req_chan.payload.command;
            n_in   = req_chan.payload.set_size;
            k_in   = req_chan.payload.subset_size;
         end
         OP_INIT: begin
            oor_in  = (n_ff > SET_W'(MAX_SET_SIZE));
            prod_in = PROD_W'(1);
            acc_in  = '0;
            i_in    = '0;
            if (n_ff > SET_W'(MAX_SET_SIZE)) begin
               lim_in = '0;
            end else if (cmd_ff == CMD_SUM) begin
               lim_in = (k_ff < n_ff) ? k_ff : n_ff;
            end else if (k_ff > n_ff) begin
               lim_in  = '0;
               prod_in = '0;
            end else begin
               // mirror k to the shorter side
               lim_in = (n_minus_k < k_ff) ? n_minus_k : k_ff;
            end
         end
         OP_ADD: begin
            if (cmd_ff == CMD_SUM)
               acc_in = acc_ff + prod_ff[VALUE_W-1:0];
         end
         OP_MUL: begin
            prod_in = mul_res;
            rem_in  = '0;
            dig_in  = '0;
         end
         OP_DIV: begin
            prod_in = div_quo;
            rem_in  = div_rem;
            dig_in  = dig_ff + DIG_W'(1);
         end
         OP_INC: begin
            i_in = i_ff + SET_W'(1);
         end
         OP_EMIT: begin
            if (emit_load) begin
               rsp_payload_in.value        = result;
               rsp_payload_in.out_of_range = oor_ff;
            end
         end
         OP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (emit_load)
         rsp_valid_in = 1'b1;
      else if (rsp_chan.ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      n_ff           <= n_in;
      k_ff           <= k_in;
      i_ff           <= i_in;
      lim_ff         <= lim_in;
      oor_ff         <= oor_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      rem_ff         <= rem_in;
      dig_ff         <= dig_in;
      rsp_payload_ff <= rsp_payload_in;
   end

`ifndef ASSERT_OFF
   // a request beat always lands in the set-up step
   a_fire_to_init: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> pc_ff == STEP_INIT)
      else $error("request beat not followed by set-up");

   // partial remainder stays below the divisor throughout a division
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_DIV) |-> ({1'b0, rem_ff} < divisor))
      else $error("divider remainder out of bound");

   // index never passes the limit while rounds run
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_ADD || pc_ff == STEP_MUL || pc_ff == STEP_DIV) |-> (i_ff <= lim_ff))
      else $error("round index past limit");

   // division leaves only after all digits are done
   a_div_complete: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_INC) |-> ($past(pc_ff) == STEP_DIV && $past(dig_ff) == DigitLast))
      else $error("division left early");

   // out-of-range responses carry zero
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.out_of_range) |-> (rsp_payload_ff.value == '0))
      else $error("out-of-range response with non-zero value");
`endif

endmodule
